/* design/keypad_set_time_of_day_clock_defines.svh */
// Assertion macros shared by the clock design.
`ifndef KEYPAD_SET_TIME_OF_DAY_CLOCK_DEFINES_SVH
`define KEYPAD_SET_TIME_OF_DAY_CLOCK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KSTC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("kstc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define KSTC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("kstc: next-cycle check failed");

`endif

/* design/kstc_pkg.sv */
package kstc_pkg;

    localparam logic [2:0] PH_IDLE        = 3'd0;
    localparam logic [2:0] PH_HOUR_TENS   = 3'd1;
    localparam logic [2:0] PH_HOUR_ONES   = 3'd2;
    localparam logic [2:0] PH_MINUTE_TENS = 3'd3;
    localparam logic [2:0] PH_MINUTE_ONES = 3'd4;
    localparam logic [2:0] PH_SECOND_TENS = 3'd5;
    localparam logic [2:0] PH_SECOND_ONES = 3'd6;
    localparam logic [2:0] PH_RUN         = 3'd7;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_START   = 3'd1;
    localparam logic [2:0] ERR_HOURS   = 3'd2;
    localparam logic [2:0] ERR_MINUTES = 3'd3;
    localparam logic [2:0] ERR_SECONDS = 3'd4;

    localparam logic [7:0] KEY_START = 8'h31;
    localparam logic [7:0] KEY_ZERO  = 8'h30;
    localparam logic [7:0] KEY_NINE  = 8'h39;

    localparam logic [5:0] SEC_LAST  = 6'd59;
    localparam logic [5:0] MIN_LAST  = 6'd59;
    localparam logic [4:0] HOUR_LAST = 5'd23;

    localparam logic [3:0] HOUR_TENS_MAX = 4'd2;
    localparam logic [3:0] HOUR_ONES_MAX = 4'd3;
    localparam logic [3:0] SIX_TENS_MAX  = 4'd5;

    typedef struct packed {
        logic [2:0] phase;
        logic [2:0] error;
        logic       key_taken;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } step_result_t;

    // Tens digit of a value below 64, as (v * 26) >> 8.
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [11:0] prod;
        prod = 12'(v) * 12'd26;
        return prod[10:8];
    endfunction

    function automatic logic [3:0] ones_of(input logic [5:0] v);
        logic [2:0] t;
        logic [5:0] rem;
        t   = tens_of(v);
        rem = v - {t, 3'b000} - {2'b00, t, 1'b0};
        return rem[3:0];
    endfunction

endpackage

/* design/kstc_clock.sv */
`include "keypad_set_time_of_day_clock_defines.svh"

module kstc_clock (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic                  action,
    input  logic [7:0]            key,
    output kstc_pkg::step_result_t result
);

    logic [2:0] phase_reg,  phase_next;
    logic [4:0] hour_reg,   hour_next;
    logic [5:0] minute_reg, minute_next;
    logic [5:0] second_reg, second_next;
    logic [2:0] err;
    logic       taken;
    logic       is_digit;
    logic [3:0] digit;
    logic [6:0] hour_wide;
    logic [6:0] minute_wide;
    logic [6:0] second_wide;

    assign is_digit = (key >= kstc_pkg::KEY_ZERO) && (key <= kstc_pkg::KEY_NINE);
    assign digit    = is_digit ? key[3:0] : 4'd0;

    assign hour_wide   = {hour_reg[3:0], 3'b000} + {1'b0, hour_reg, 1'b0} + 7'(digit);
    assign minute_wide = {minute_reg[3:0], 3'b000} + {minute_reg, 1'b0} + 7'(digit);
    assign second_wide = {second_reg[3:0], 3'b000} + {second_reg, 1'b0} + 7'(digit);

    always_comb begin
        phase_next  = phase_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        err         = kstc_pkg::ERR_NONE;
        taken       = 1'b0;
        if (action) begin
            if (phase_reg == kstc_pkg::PH_RUN) begin
                if (second_reg < kstc_pkg::SEC_LAST) begin
                    second_next = second_reg + 6'd1;
                end else if (minute_reg < kstc_pkg::MIN_LAST) begin
                    minute_next = minute_reg + 6'd1;
                    second_next = '0;
                end else if (hour_reg < kstc_pkg::HOUR_LAST) begin
                    hour_next   = hour_reg + 5'd1;
                    minute_next = '0;
                    second_next = '0;
                end else begin
                    hour_next   = '0;
                    minute_next = '0;
                    second_next = '0;
                end
            end
        end else begin
            unique case (phase_reg)
                kstc_pkg::PH_IDLE: begin
                    if (key == kstc_pkg::KEY_START) phase_next = kstc_pkg::PH_HOUR_TENS;
                    else err = kstc_pkg::ERR_START;
                end
                kstc_pkg::PH_HOUR_TENS: begin
                    if (is_digit && digit <= kstc_pkg::HOUR_TENS_MAX) begin
                        hour_next  = 5'(digit);
                        phase_next = kstc_pkg::PH_HOUR_ONES;
                        taken      = 1'b1;
                    end else begin
                        err = kstc_pkg::ERR_HOURS;
                    end
                end
                kstc_pkg::PH_HOUR_ONES: begin
                    if (is_digit && !(hour_reg == 5'd2 && digit > kstc_pkg::HOUR_ONES_MAX)) begin
                        hour_next  = hour_wide[4:0];
                        phase_next = kstc_pkg::PH_MINUTE_TENS;
                        taken      = 1'b1;
                    end else begin
                        err        = kstc_pkg::ERR_HOURS;
                        phase_next = kstc_pkg::PH_HOUR_TENS;
                    end
                end
                kstc_pkg::PH_MINUTE_TENS: begin
                    if (is_digit && digit <= kstc_pkg::SIX_TENS_MAX) begin
                        minute_next = 6'(digit);
                        phase_next  = kstc_pkg::PH_MINUTE_ONES;
                        taken       = 1'b1;
                    end else begin
                        err = kstc_pkg::ERR_MINUTES;
                    end
                end
                kstc_pkg::PH_MINUTE_ONES: begin
                    if (is_digit) begin
                        minute_next = minute_wide[5:0];
                        phase_next  = kstc_pkg::PH_SECOND_TENS;
                        taken       = 1'b1;
                    end else begin
                        err        = kstc_pkg::ERR_MINUTES;
                        phase_next = kstc_pkg::PH_MINUTE_TENS;
                    end
                end
                kstc_pkg::PH_SECOND_TENS: begin
                    if (is_digit && digit <= kstc_pkg::SIX_TENS_MAX) begin
                        second_next = 6'(digit);
                        phase_next  = kstc_pkg::PH_SECOND_ONES;
                        taken       = 1'b1;
                    end else begin
                        err = kstc_pkg::ERR_SECONDS;
                    end
                end
                kstc_pkg::PH_SECOND_ONES: begin
                    if (is_digit) begin
                        second_next = second_wide[5:0];
                        phase_next  = kstc_pkg::PH_RUN;
                        taken       = 1'b1;
                    end else begin
                        err        = kstc_pkg::ERR_SECONDS;
                        phase_next = kstc_pkg::PH_SECOND_TENS;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= kstc_pkg::PH_IDLE;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
        end
    end

    assign result.phase     = phase_next;
    assign result.error     = err;
    assign result.key_taken = taken;
    assign result.hour      = hour_next;
    assign result.minute    = minute_next;
    assign result.second    = second_next;

    `KSTC_ASSERT_NEXT(a_run_holds, aclk, aresetn,
        step && action && phase_reg == kstc_pkg::PH_RUN, phase_reg == kstc_pkg::PH_RUN)
    `KSTC_ASSERT_NEXT(a_start_key, aclk, aresetn,
        step && !action && phase_reg == kstc_pkg::PH_IDLE && key == kstc_pkg::KEY_START,
        phase_reg == kstc_pkg::PH_HOUR_TENS)
    `KSTC_ASSERT_NEXT(a_idle_hold, aclk, aresetn,
        !step, $stable(phase_reg) && $stable(second_reg))

endmodule

/* design/keypad_set_time_of_day_clock.sv */
// Throughput: one request per cycle unless the output stalls with m_ready low,
// set by the input register, clock update logic and result register in a single pass.
// Reset (aresetn low, synchronous) empties both stages and returns the clock
// to idle at 00:00:00.
`include "keypad_set_time_of_day_clock_defines.svh"

module keypad_set_time_of_day_clock (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_key,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_phase,
    output logic [2:0] m_error,
    output logic       m_key_taken,
    output logic [1:0] m_hour_tens,
    output logic [3:0] m_hour_ones,
    output logic [2:0] m_minute_tens,
    output logic [3:0] m_minute_ones,
    output logic [2:0] m_second_tens,
    output logic [3:0] m_second_ones
);

    logic       in_valid_reg;
    logic       in_action_reg;
    logic [7:0] in_key_reg;
    logic       out_valid_reg;
    logic       out_free;
    logic       advance;
    kstc_pkg::step_result_t step_res;

    logic [2:0] phase_reg;
    logic [2:0] error_reg;
    logic       key_taken_reg;
    logic [1:0] hour_tens_reg;
    logic [3:0] hour_ones_reg;
    logic [2:0] minute_tens_reg;
    logic [3:0] minute_ones_reg;
    logic [2:0] second_tens_reg;
    logic [3:0] second_ones_reg;
    logic [2:0] hour_tens_wide;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_action_reg <= s_action;
            in_key_reg    <= s_key;
        end
    end

    kstc_clock u_clock (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step   (advance),
        .action (in_action_reg),
        .key    (in_key_reg),
        .result (step_res)
    );

    assign hour_tens_wide = kstc_pkg::tens_of({1'b0, step_res.hour});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            phase_reg       <= step_res.phase;
            error_reg       <= step_res.error;
            key_taken_reg   <= step_res.key_taken;
            hour_tens_reg   <= hour_tens_wide[1:0];
            hour_ones_reg   <= kstc_pkg::ones_of({1'b0, step_res.hour});
            minute_tens_reg <= kstc_pkg::tens_of(step_res.minute);
            minute_ones_reg <= kstc_pkg::ones_of(step_res.minute);
            second_tens_reg <= kstc_pkg::tens_of(step_res.second);
            second_ones_reg <= kstc_pkg::ones_of(step_res.second);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_phase       = phase_reg;
    assign m_error       = error_reg;
    assign m_key_taken   = key_taken_reg;
    assign m_hour_tens   = hour_tens_reg;
    assign m_hour_ones   = hour_ones_reg;
    assign m_minute_tens = minute_tens_reg;
    assign m_minute_ones = minute_ones_reg;
    assign m_second_tens = second_tens_reg;
    assign m_second_ones = second_ones_reg;

    `KSTC_ASSERT_NOW(a_taken_no_error, aclk, aresetn,
        m_valid && m_key_taken, m_error == kstc_pkg::ERR_NONE)
    `KSTC_ASSERT_NOW(a_start_err_idle, aclk, aresetn,
        m_valid && m_error == kstc_pkg::ERR_START, m_phase == kstc_pkg::PH_IDLE)
    `KSTC_ASSERT_NOW(a_stall_full, aclk, aresetn,
        !s_ready, in_valid_reg && out_valid_reg)

endmodule

/* bench/tb_keypad_set_time_of_day_clock.sv */
module tb_keypad_set_time_of_day_clock;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_KEY  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_REQUESTS = 1850;
    localparam int DRAIN_CYCLES    = 8;

    typedef struct packed {
        logic [2:0] phase;
        logic [2:0] error;
        logic       key_taken;
        logic [1:0] hour_tens;
        logic [3:0] hour_ones;
        logic [2:0] minute_tens;
        logic [3:0] minute_ones;
        logic [2:0] second_tens;
        logic [3:0] second_ones;
    } display_t;

    typedef enum int {
        NOISE_NON_DIGIT,
        NOISE_TENS_HIGH,
        NOISE_ONES_BAD,
        NOISE_TICK
    } entry_noise_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_action;
    logic [7:0] s_key;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_phase;
    logic [2:0] m_error;
    logic       m_key_taken;
    logic [1:0] m_hour_tens;
    logic [3:0] m_hour_ones;
    logic [2:0] m_minute_tens;
    logic [3:0] m_minute_ones;
    logic [2:0] m_second_tens;
    logic [3:0] m_second_ones;

    logic [2:0] clk_phase  = kstc_pkg::PH_IDLE;
    logic [4:0] clk_hour   = '0;
    logic [5:0] clk_minute = '0;
    logic [5:0] clk_second = '0;

    display_t expected_displays[$];
    int       fail_count  = 0;
    int       cycle_count = 0;
    int       ready_hold  = 0;
    bit       burst_mode  = 1'b0;

    keypad_set_time_of_day_clock i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_phase       (m_phase),
        .m_error       (m_error),
        .m_key_taken   (m_key_taken),
        .m_hour_tens   (m_hour_tens),
        .m_hour_ones   (m_hour_ones),
        .m_minute_tens (m_minute_tens),
        .m_minute_ones (m_minute_ones),
        .m_second_tens (m_second_tens),
        .m_second_ones (m_second_ones)
    );

    always #10 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] digit_key(input logic [3:0] d);
        return kstc_pkg::KEY_ZERO + 8'(d);
    endfunction

    function automatic logic [7:0] non_digit_key();
        logic [7:0] k;
        k = 8'($urandom);
        while (k >= kstc_pkg::KEY_ZERO && k <= kstc_pkg::KEY_NINE) k = 8'($urandom);
        return k;
    endfunction

    function automatic void advance_second();
        if (clk_second < kstc_pkg::SEC_LAST) begin
            clk_second = clk_second + 6'd1;
        end else if (clk_minute < kstc_pkg::MIN_LAST) begin
            clk_minute = clk_minute + 6'd1;
            clk_second = '0;
        end else if (clk_hour < kstc_pkg::HOUR_LAST) begin
            clk_hour   = clk_hour + 5'd1;
            clk_minute = '0;
            clk_second = '0;
        end else begin
            clk_hour   = '0;
            clk_minute = '0;
            clk_second = '0;
        end
    endfunction

    function automatic display_t predict_display(input logic action, input logic [7:0] key);
        display_t   d;
        logic       is_digit;
        int         digit;
        logic [2:0] err;
        logic       taken;
        is_digit = (key >= kstc_pkg::KEY_ZERO) && (key <= kstc_pkg::KEY_NINE);
        digit    = is_digit ? int'(key - kstc_pkg::KEY_ZERO) : 0;
        err      = kstc_pkg::ERR_NONE;
        taken    = 1'b0;
        if (action == ACT_TICK) begin
            if (clk_phase == kstc_pkg::PH_RUN) advance_second();
        end else begin
            case (clk_phase)
                kstc_pkg::PH_IDLE: begin
                    if (key == kstc_pkg::KEY_START) clk_phase = kstc_pkg::PH_HOUR_TENS;
                    else err = kstc_pkg::ERR_START;
                end
                kstc_pkg::PH_HOUR_TENS: begin
                    if (is_digit && digit <= kstc_pkg::HOUR_TENS_MAX) begin
                        clk_hour  = 5'(digit);
                        clk_phase = kstc_pkg::PH_HOUR_ONES;
                        taken     = 1'b1;
                    end else begin
                        err = kstc_pkg::ERR_HOURS;
                    end
                end
                kstc_pkg::PH_HOUR_ONES: begin
                    if (is_digit && !(clk_hour == kstc_pkg::HOUR_TENS_MAX &&
                                      digit > kstc_pkg::HOUR_ONES_MAX)) begin
                        clk_hour  = 5'(clk_hour * 10 + digit);
                        clk_phase = kstc_pkg::PH_MINUTE_TENS;
                        taken     = 1'b1;
                    end else begin
                        err       = kstc_pkg::ERR_HOURS;
                        clk_phase = kstc_pkg::PH_HOUR_TENS;
                    end
                end
                kstc_pkg::PH_MINUTE_TENS: begin
                    if (is_digit && digit <= kstc_pkg::SIX_TENS_MAX) begin
                        clk_minute = 6'(digit);
                        clk_phase  = kstc_pkg::PH_MINUTE_ONES;
                        taken      = 1'b1;
                    end else begin
                        err = kstc_pkg::ERR_MINUTES;
                    end
                end
                kstc_pkg::PH_MINUTE_ONES: begin
                    if (is_digit) begin
                        clk_minute = 6'(clk_minute * 10 + digit);
                        clk_phase  = kstc_pkg::PH_SECOND_TENS;
                        taken      = 1'b1;
                    end else begin
                        err       = kstc_pkg::ERR_MINUTES;
                        clk_phase = kstc_pkg::PH_MINUTE_TENS;
                    end
                end
                kstc_pkg::PH_SECOND_TENS: begin
                    if (is_digit && digit <= kstc_pkg::SIX_TENS_MAX) begin
                        clk_second = 6'(digit);
                        clk_phase  = kstc_pkg::PH_SECOND_ONES;
                        taken      = 1'b1;
                    end else begin
                        err = kstc_pkg::ERR_SECONDS;
                    end
                end
                kstc_pkg::PH_SECOND_ONES: begin
                    if (is_digit) begin
                        clk_second = 6'(clk_second * 10 + digit);
                        clk_phase  = kstc_pkg::PH_RUN;
                        taken      = 1'b1;
                    end else begin
                        err       = kstc_pkg::ERR_SECONDS;
                        clk_phase = kstc_pkg::PH_SECOND_TENS;
                    end
                end
                default: begin
                end
            endcase
        end
        d.phase       = clk_phase;
        d.error       = err;
        d.key_taken   = taken;
        d.hour_tens   = 2'(clk_hour / 10);
        d.hour_ones   = 4'(clk_hour % 10);
        d.minute_tens = 3'(clk_minute / 10);
        d.minute_ones = 4'(clk_minute % 10);
        d.second_tens = 3'(clk_second / 10);
        d.second_ones = 4'(clk_second % 10);
        return d;
    endfunction

    task automatic send_request(input logic action, input logic [7:0] key);
        int gap;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= action;
        s_key    <= key;
        expected_displays.push_back(predict_display(action, key));
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready <= 1'b1;
            if (!burst_mode && $urandom_range(0, 3) == 0) ready_hold <= pick_gap();
        end
    end

    always @(posedge aclk) begin : check_results
        display_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_displays.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                want = expected_displays.pop_front();
                check_field("phase", int'(want.phase), int'(m_phase));
                check_field("error", int'(want.error), int'(m_error));
                check_field("key_taken", int'(want.key_taken), int'(m_key_taken));
                check_field("hour_tens", int'(want.hour_tens), int'(m_hour_tens));
                check_field("hour_ones", int'(want.hour_ones), int'(m_hour_ones));
                check_field("minute_tens", int'(want.minute_tens), int'(m_minute_tens));
                check_field("minute_ones", int'(want.minute_ones), int'(m_minute_ones));
                check_field("second_tens", int'(want.second_tens), int'(m_second_tens));
                check_field("second_ones", int'(want.second_ones), int'(m_second_ones));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL keypad_set_time_of_day_clock");
            $finish;
        end
    end

    task automatic test_idle_keys();
        send_request(ACT_TICK, 8'hff);
        send_request(ACT_KEY, 8'h00);
        send_request(ACT_KEY, kstc_pkg::KEY_ZERO);
        send_request(ACT_KEY, 8'hff);
        send_request(ACT_KEY, kstc_pkg::KEY_START);
    endtask

    task automatic test_hour_entry_errors();
        send_request(ACT_KEY, kstc_pkg::KEY_NINE + 8'd1);
        send_request(ACT_KEY, digit_key(kstc_pkg::HOUR_TENS_MAX + 4'd1));
        send_request(ACT_KEY, digit_key(kstc_pkg::HOUR_TENS_MAX));
        send_request(ACT_KEY, digit_key(kstc_pkg::HOUR_ONES_MAX + 4'd1));
        send_request(ACT_KEY, digit_key(kstc_pkg::HOUR_TENS_MAX));
        send_request(ACT_KEY, kstc_pkg::KEY_ZERO - 8'd1);
        send_request(ACT_TICK, 8'h00);
    endtask

    task automatic enter_field_noisy(input logic [3:0] tens_max, input bit hours,
                                     input logic [3:0] tens, input logic [3:0] ones);
        int           attempts;
        entry_noise_t kind;
        logic [3:0]   first;
        attempts = $urandom_range(3, 15);
        repeat (attempts) begin
            kind = entry_noise_t'($urandom_range(0, 3));
            case (kind)
                NOISE_NON_DIGIT: send_request(ACT_KEY, non_digit_key());
                NOISE_TENS_HIGH:
                    send_request(ACT_KEY, digit_key(4'($urandom_range(tens_max + 1, 9))));
                NOISE_ONES_BAD: begin
                    first = 4'($urandom_range(0, tens_max));
                    send_request(ACT_KEY, digit_key(first));
                    if (hours && first == kstc_pkg::HOUR_TENS_MAX && $urandom_range(0, 1) == 1)
                        send_request(ACT_KEY,
                            digit_key(4'($urandom_range(kstc_pkg::HOUR_ONES_MAX + 1, 9))));
                    else
                        send_request(ACT_KEY, non_digit_key());
                end
                default: send_request(ACT_TICK, 8'($urandom));
            endcase
        end
        send_request(ACT_KEY, digit_key(tens));
        send_request(ACT_KEY, digit_key(ones));
    endtask

    task automatic test_noisy_entry();
        enter_field_noisy(kstc_pkg::HOUR_TENS_MAX, 1'b1, kstc_pkg::HOUR_TENS_MAX,
                          kstc_pkg::HOUR_ONES_MAX);
        enter_field_noisy(kstc_pkg::SIX_TENS_MAX, 1'b0, kstc_pkg::SIX_TENS_MAX, 4'd9);
        enter_field_noisy(kstc_pkg::SIX_TENS_MAX, 1'b0, kstc_pkg::SIX_TENS_MAX, 4'd8);
    endtask

    task automatic test_midnight_rollover();
        send_request(ACT_TICK, 8'h00);
        send_request(ACT_TICK, 8'hff);
        send_request(ACT_KEY, 8'hff);
        send_request(ACT_KEY, kstc_pkg::KEY_START);
        send_request(ACT_TICK, 8'h55);
    endtask

    task automatic test_random_running();
        int sent;
        int chunk;
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            burst_mode <= ($urandom_range(0, 4) == 0);
            chunk = $urandom_range(20, 120);
            repeat (chunk) begin
                if ($urandom_range(0, 99) < 70) send_request(ACT_TICK, 8'($urandom));
                else send_request(ACT_KEY, 8'($urandom));
                sent++;
            end
        end
        burst_mode <= 1'b0;
    endtask

    initial begin
        s_valid  <= 1'b0;
        s_action <= ACT_KEY;
        s_key    <= 8'h00;
        aresetn  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_keys();
        test_hour_entry_errors();
        test_noisy_entry();
        test_midnight_rollover();
        test_random_running();
        s_valid <= 1'b0;
        while (expected_displays.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS keypad_set_time_of_day_clock");
        end else begin
            $display("FAIL keypad_set_time_of_day_clock");
        end
        $finish;
    end

endmodule
